>>> rtl/grr_pkg.sv
// Shared types, result codes and the built-in digit table for the glyph row renderer.
package grr_pkg;

  localparam logic [1:0] KIND_COLWIN = 2'd0;
  localparam logic [1:0] KIND_ROWWIN = 2'd1;
  localparam logic [1:0] KIND_PIXEL  = 2'd2;

  localparam logic [1:0] REG_PANEL_WIDTH   = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

  localparam logic [9:0] PANEL_WIDTH_RESET  = 10'd240;
  localparam logic [9:0] PANEL_HEIGHT_RESET = 10'd320;

  localparam logic [7:0] CHAR_LOW   = 8'd32;
  localparam logic [7:0] CHAR_HIGH  = 8'd126;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] XSPAN_1X = 4'd5;
  localparam logic [3:0] XSPAN_2X = 4'd11;
  localparam logic [3:0] YSPAN_1X = 4'd7;
  localparam logic [3:0] YSPAN_2X = 4'd15;

  localparam logic [4:0] LAST_POS_1X = 5'd7;
  localparam logic [4:0] LAST_POS_2X = 5'd25;
  localparam logic [4:0] FIRST_PIXEL_POS = 5'd2;

  // One classified item, ready for the result sequencer.
  typedef struct packed {
    logic        has_win;
    logic        dbl;
    logic [4:0]  bits5;
    logic [15:0] fg;
    logic [15:0] bg;
    logic [11:0] col_start;
    logic [11:0] col_end;
    logic [11:0] row_start;
    logic [11:0] row_end;
  } job_t;

  // Rows of a digit glyph, element 0 is the top row.
  function automatic logic [7:0][4:0] digit_rows(input logic [3:0] d);
    logic [7:0][4:0] r;
    case (d)
      4'd0: r = {5'h00, 5'h0E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h0E};
      4'd1: r = {5'h00, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0C, 5'h04};
      4'd2: r = {5'h00, 5'h1F, 5'h08, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      4'd3: r = {5'h00, 5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      4'd4: r = {5'h00, 5'h02, 5'h02, 5'h1F, 5'h12, 5'h0A, 5'h06, 5'h02};
      4'd5: r = {5'h00, 5'h0E, 5'h11, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h1F};
      4'd6: r = {5'h00, 5'h0E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h08, 5'h06};
      4'd7: r = {5'h00, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02, 5'h01, 5'h1F};
      4'd8: r = {5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      4'd9: r = {5'h00, 5'h0C, 5'h02, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0E};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/grr_front.sv
// Front end: configuration registers, clipping and classification of each item.
module grr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [9:0]        wr_data,
  input  logic              accept,
  input  logic [9:0]        cell_x,
  input  logic [9:0]        cell_y,
  input  logic [7:0]        char_code,
  input  logic [2:0]        glyph_row_index,
  input  logic [7:0]        font_byte,
  input  logic [15:0]       fore_colour,
  input  logic [15:0]       back_colour,
  input  logic              double_size,
  output logic              job_push,
  output grr_pkg::job_t     job
);
  import grr_pkg::*;

  logic [9:0] panel_width;
  logic [9:0] panel_height;
  logic [9:0] column_offset;
  logic [9:0] row_offset;

  logic [7:0]  ch;
  logic [3:0]  xspan;
  logic [3:0]  yspan;
  logic [10:0] x_right;
  logic [10:0] y_bottom;
  logic        clipped;
  logic        is_digit;
  logic [7:0][4:0] drows;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width   <= PANEL_WIDTH_RESET;
      panel_height  <= PANEL_HEIGHT_RESET;
      column_offset <= '0;
      row_offset    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PANEL_WIDTH:   panel_width   <= wr_data;
        REG_PANEL_HEIGHT:  panel_height  <= wr_data;
        REG_COLUMN_OFFSET: column_offset <= wr_data;
        REG_ROW_OFFSET:    row_offset    <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ch = (char_code < CHAR_LOW || char_code > CHAR_HIGH) ? CHAR_QMARK : char_code;
    xspan = double_size ? XSPAN_2X : XSPAN_1X;
    yspan = double_size ? YSPAN_2X : YSPAN_1X;
    x_right  = {1'b0, cell_x} + {7'd0, xspan};
    y_bottom = {1'b0, cell_y} + {7'd0, yspan};
    clipped  = (x_right >= {1'b0, panel_width}) || (y_bottom >= {1'b0, panel_height});
    is_digit = double_size && ch >= CHAR_ZERO && ch <= CHAR_NINE;
    drows    = digit_rows(ch[3:0]);

    job.has_win   = (glyph_row_index == 3'd0);
    job.dbl       = double_size;
    job.bits5     = is_digit ? drows[glyph_row_index] : font_byte[7:3];
    job.fg        = fore_colour;
    job.bg        = back_colour;
    job.col_start = {2'b0, cell_x} + {2'b0, column_offset};
    job.col_end   = {2'b0, cell_x} + {2'b0, column_offset} + {8'd0, xspan};
    job.row_start = {2'b0, cell_y} + {2'b0, row_offset};
    job.row_end   = {2'b0, cell_y} + {2'b0, row_offset} + {8'd0, yspan};
  end

  // A clipped cell is taken and dropped here; it never reaches the queue.
  assign job_push = accept && !clipped;

endmodule

>>> rtl/grr_job_q.sv
// Two-entry queue of classified items between the front end and the sequencer.
module grr_job_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  grr_pkg::job_t  wdata,
  input  logic           pop,
  output grr_pkg::job_t  rdata,
  output logic           full,
  output logic           empty
);
  import grr_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign rdata = entries[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

>>> rtl/grr_back.sv
// Result sequencer: walks one queued item through its windows and pixels into the output register.
module grr_back (
  input  logic           clk,
  input  logic           rst,
  input  grr_pkg::job_t  job,
  input  logic           job_avail,
  output logic           job_pop,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     result_kind,
  output logic [11:0]    window_start,
  output logic [11:0]    window_end,
  output logic [15:0]    pixel_colour,
  output logic           last_of_run
);
  import grr_pkg::*;

  logic       out_valid;
  logic [4:0] cnt;
  logic [4:0] cnt_next;
  logic       out_load;
  logic [4:0] pos;
  logic [4:0] pix;
  logic [4:0] pix_mod;
  logic [2:0] col;
  logic [5:0] line_bits;
  logic       is_last;
  logic [1:0]  kind_next;
  logic [11:0] ws_next;
  logic [11:0] we_next;
  logic [15:0] colour_next;

  assign out_load = job_avail && (!out_valid || pop);

  always_comb begin
    pos = cnt + (job.has_win ? 5'd0 : FIRST_PIXEL_POS);
    pix = pos - FIRST_PIXEL_POS;
    pix_mod = (pix >= 5'd12) ? pix - 5'd12 : pix;
    col = job.dbl ? pix_mod[3:1] : pix[2:0];
    line_bits = {job.bits5, 1'b0};
    is_last = (pos == (job.dbl ? LAST_POS_2X : LAST_POS_1X));
    kind_next = KIND_PIXEL;
    ws_next = '0;
    we_next = '0;
    colour_next = '0;
    if (pos == 5'd0) begin
      kind_next = KIND_COLWIN;
      ws_next = job.col_start;
      we_next = job.col_end;
    end else if (pos == 5'd1) begin
      kind_next = KIND_ROWWIN;
      ws_next = job.row_start;
      we_next = job.row_end;
    end else begin
      colour_next = line_bits[3'd5 - col] ? job.fg : job.bg;
    end
    cnt_next = is_last ? 5'd0 : cnt + 5'd1;
  end

  assign job_pop = out_load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        cnt       <= cnt_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind  <= kind_next;
      window_start <= ws_next;
      window_end   <= we_next;
      pixel_colour <= colour_next;
      last_of_run  <= is_last;
    end
  end

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_POS_2X) else $error("sequencer count out of range");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (out_valid && last_of_run)) else $error("item retired without last result");
  a_window_no_colour: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KIND_PIXEL) |-> (pixel_colour == 16'd0))
    else $error("window result carries a colour");
  a_idle_restart: assert property (@(posedge clk) disable iff (rst)
    !job_avail |-> (cnt == 5'd0)) else $error("sequencer mid-item with no item queued");
`endif

endmodule

>>> rtl/glyph_row_pixel_renderer.sv
// Top level of the glyph row renderer: front end, item queue and result sequencer.
//
//   channel   direction  handshake      payload
//   input     in         push / full    cell_x cell_y char_code glyph_row_index font_byte
//                                       fore_colour back_colour double_size
//   result    out        pop / empty    result_kind window_start window_end pixel_colour
//                                       last_of_run
//   config    in         wr_en          wr_index wr_data
//
// The sequencer makes one result per cycle unless the output stalls. An item has 6 or
// 8 results at 1x, 24 or 26 at 2x (row 0 adds the two windows); a clipped item is
// dropped at the input. An accepted item enters the queue before its first result is
// loaded into the output register. A two-entry queue holds items waiting for the
// sequencer, so input is taken while results are still being drained. Reset empties
// the queue and the output register and returns the registers to their reset values.
module glyph_row_pixel_renderer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [9:0]  cell_x,
  input  logic [9:0]  cell_y,
  input  logic [7:0]  char_code,
  input  logic [2:0]  glyph_row_index,
  input  logic [7:0]  font_byte,
  input  logic [15:0] fore_colour,
  input  logic [15:0] back_colour,
  input  logic        double_size,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [11:0] window_start,
  output logic [11:0] window_end,
  output logic [15:0] pixel_colour,
  output logic        last_of_run,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [9:0]  wr_data
);
  import grr_pkg::*;

  job_t in_job;
  job_t q_job;
  logic q_push;
  logic q_pop;
  logic q_empty;

  grr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .accept          (push && !full),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .char_code       (char_code),
    .glyph_row_index (glyph_row_index),
    .font_byte       (font_byte),
    .fore_colour     (fore_colour),
    .back_colour     (back_colour),
    .double_size     (double_size),
    .job_push        (q_push),
    .job             (in_job)
  );

  grr_job_q u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (in_job),
    .pop   (q_pop),
    .rdata (q_job),
    .full  (full),
    .empty (q_empty)
  );

  grr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (q_job),
    .job_avail    (!q_empty),
    .job_pop      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .result_kind  (result_kind),
    .window_start (window_start),
    .window_end   (window_end),
    .pixel_colour (pixel_colour),
    .last_of_run  (last_of_run)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the glyph row renderer: directed cells, register extremes and random text.
module tb;
  import grr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PERCENT = 27;

  typedef struct packed {
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [7:0]  ch;
    logic [2:0]  row;
    logic [7:0]  fbyte;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        dbl;
  } glyph_row_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] wstart;
    logic [11:0] wend;
    logic [15:0] colour;
    logic        last;
  } render_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [9:0]  cell_x = '0;
  logic [9:0]  cell_y = '0;
  logic [7:0]  char_code = '0;
  logic [2:0]  glyph_row_index = '0;
  logic [7:0]  font_byte = '0;
  logic [15:0] fore_colour = '0;
  logic [15:0] back_colour = '0;
  logic        double_size = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind;
  logic [11:0] window_start;
  logic [11:0] window_end;
  logic [15:0] pixel_colour;
  logic        last_of_run;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [9:0]  wr_data = '0;

  // Local copy of the panel registers.
  logic [9:0] panel_width = PANEL_WIDTH_RESET;
  logic [9:0] panel_height = PANEL_HEIGHT_RESET;
  logic [9:0] column_offset = '0;
  logic [9:0] row_offset = '0;

  render_out_t render_queue[$];
  render_out_t want;
  int          mismatches = 0;
  int          rows_rendered = 0;
  int          cycles = 0;
  logic        steady = 1'b0;

  glyph_row_pixel_renderer u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .char_code(char_code),
    .glyph_row_index(glyph_row_index),
    .font_byte(font_byte),
    .fore_colour(fore_colour),
    .back_colour(back_colour),
    .double_size(double_size),
    .empty(empty),
    .pop(pop),
    .result_kind(result_kind),
    .window_start(window_start),
    .window_end(window_end),
    .pixel_colour(pixel_colour),
    .last_of_run(last_of_run),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Five-bit rows of the built-in digit glyphs, top row in the upper bits.
  function automatic logic [4:0] digit_row(input int d, input int r);
    logic [39:0] glyph;
    case (d)
      0: glyph = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E, 5'h00};
      1: glyph = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E, 5'h00};
      2: glyph = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F, 5'h00};
      3: glyph = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E, 5'h00};
      4: glyph = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02, 5'h00};
      5: glyph = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E, 5'h00};
      6: glyph = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E, 5'h00};
      7: glyph = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h00};
      8: glyph = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00};
      9: glyph = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C, 5'h00};
      default: glyph = '0;
    endcase
    return glyph[39 - 5 * r -: 5];
  endfunction

  // Queues the windows and pixels that one glyph row should produce; returns their count.
  function automatic int predict_row_render(input glyph_row_t g);
    int          xs;
    int          ys;
    int          n;
    int          k;
    logic [7:0]  ch;
    logic [4:0]  bits;
    logic [15:0] colour;
    render_out_t r;
    xs = g.dbl ? int'(XSPAN_2X) : int'(XSPAN_1X);
    ys = g.dbl ? int'(YSPAN_2X) : int'(YSPAN_1X);
    ch = (g.ch < CHAR_LOW || g.ch > CHAR_HIGH) ? CHAR_QMARK : g.ch;
    if (int'(g.cx) + xs >= int'(panel_width) || int'(g.cy) + ys >= int'(panel_height))
      return 0;
    bits = g.fbyte[7:3];
    if (g.dbl && ch >= CHAR_ZERO && ch <= CHAR_NINE)
      bits = digit_row(int'(ch) - int'(CHAR_ZERO), int'(g.row));
    n = (g.dbl ? 24 : 6) + (g.row == 3'd0 ? 2 : 0);
    k = 0;
    if (g.row == 3'd0) begin
      r = '{KIND_COLWIN, 12'(int'(g.cx) + int'(column_offset)),
            12'(int'(g.cx) + xs + int'(column_offset)), 16'h0000, 1'b0};
      render_queue.push_back(r);
      r = '{KIND_ROWWIN, 12'(int'(g.cy) + int'(row_offset)),
            12'(int'(g.cy) + ys + int'(row_offset)), 16'h0000, 1'b0};
      render_queue.push_back(r);
      k = 2;
    end
    for (int line = 0; line < (g.dbl ? 2 : 1); line++) begin
      for (int col = 0; col < 6; col++) begin
        colour = (col < 5 && bits[4 - col]) ? g.fg : g.bg;
        for (int rep = 0; rep < (g.dbl ? 2 : 1); rep++) begin
          k++;
          r = '{KIND_PIXEL, 12'h000, 12'h000, colour, k == n};
          render_queue.push_back(r);
        end
      end
    end
    return n;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_glyph_row(input logic [9:0] x, y, input logic [7:0] ch,
                                input logic [2:0] row, input logic [7:0] fb,
                                input logic [15:0] fg, bg, input logic dbl);
    glyph_row_t g;
    g = '{x, y, ch, row, fb, fg, bg, dbl};
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    cell_x <= x;
    cell_y <= y;
    char_code <= ch;
    glyph_row_index <= row;
    font_byte <= fb;
    fore_colour <= fg;
    back_colour <= bg;
    double_size <= dbl;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_row_render(g) > 0) rows_rendered++;
    @(negedge clk);
  endtask

  // Stops pushing and waits until every expected result is out; clipped items never enter the pipeline.
  task automatic drain_results();
    push <= 1'b0;
    while (render_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure_panel(input logic [9:0] w, h, co, ro);
    wr_en <= 1'b1;
    wr_index <= REG_PANEL_WIDTH;
    wr_data <= w;
    @(negedge clk);
    wr_index <= REG_PANEL_HEIGHT;
    wr_data <= h;
    @(negedge clk);
    wr_index <= REG_COLUMN_OFFSET;
    wr_data <= co;
    @(negedge clk);
    wr_index <= REG_ROW_OFFSET;
    wr_data <= ro;
    @(negedge clk);
    wr_en <= 1'b0;
    panel_width = w;
    panel_height = h;
    column_offset = co;
    row_offset = ro;
  endtask

  // Reset panel size: cells on the right and bottom edges, and one past them.
  task automatic test_reset_geometry();
    send_glyph_row(10'd0, 10'd0, "A", 3'd0, 8'hF8, 16'hFFFF, 16'h0000, 1'b0);
    send_glyph_row(10'd234, 10'd312, "A", 3'd1, 8'h00, 16'h0000, 16'hFFFF, 1'b0);
    send_glyph_row(10'd235, 10'd0, "A", 3'd0, 8'hFF, 16'h1234, 16'h5678, 1'b0);
    send_glyph_row(10'd0, 10'd313, "A", 3'd0, 8'hFF, 16'h1234, 16'h5678, 1'b0);
    send_glyph_row(10'd228, 10'd304, "8", 3'd0, 8'h00, 16'hFFFF, 16'h0000, 1'b1);
    send_glyph_row(10'd229, 10'd0, "8", 3'd0, 8'h00, 16'hFFFF, 16'h0000, 1'b1);
    send_glyph_row(10'd0, 10'd305, "8", 3'd0, 8'h00, 16'hFFFF, 16'h0000, 1'b1);
  endtask

  // Digit table at 2x, the digit bounds, and codes that fall back to the question mark.
  task automatic test_character_classes();
    for (int d = 0; d < 10; d++)
      send_glyph_row(10'(12 * d), 10'd20, CHAR_ZERO + 8'(d), 3'(d % 8), 8'hFF,
                     16'hF800, 16'h001F, 1'b1);
    send_glyph_row(10'd30, 10'd40, "5", 3'd2, 8'hA8, 16'h07E0, 16'hAAAA, 1'b0);
    send_glyph_row(10'd40, 10'd40, 8'd31, 3'd3, 8'h57, 16'h7FFF, 16'h8000, 1'b1);
    send_glyph_row(10'd60, 10'd40, 8'd127, 3'd0, 8'hA8, 16'h8000, 16'h7FFF, 1'b1);
    send_glyph_row(10'd80, 10'd40, 8'd255, 3'd7, 8'h88, 16'h5555, 16'hAAAA, 1'b0);
    send_glyph_row(10'd90, 10'd40, 8'd0, 3'd5, 8'h07, 16'hFFFF, 16'h0000, 1'b1);
    send_glyph_row(10'd110, 10'd40, CHAR_LOW, 3'd4, 8'hD8, 16'h0F0F, 16'hF0F0, 1'b1);
    send_glyph_row(10'd130, 10'd40, CHAR_HIGH, 3'd6, 8'h70, 16'hF0F0, 16'h0F0F, 1'b0);
    send_glyph_row(10'd140, 10'd40, 8'h2F, 3'd1, 8'h57, 16'h0001, 16'hFFFE, 1'b1);
    send_glyph_row(10'd160, 10'd40, 8'h3A, 3'd2, 8'h57, 16'hFFFE, 16'h0001, 1'b1);
  endtask

  task automatic test_register_extremes();
    drain_results();
    configure_panel(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_glyph_row(10'd1011, 10'd1007, "3", 3'd0, 8'h00, 16'hFFFF, 16'h0000, 1'b1);
    send_glyph_row(10'd1012, 10'd0, "3", 3'd0, 8'h00, 16'hFFFF, 16'h0000, 1'b1);
    send_glyph_row(10'd1017, 10'd1015, "W", 3'd0, 8'hA8, 16'h0000, 16'hFFFF, 1'b0);
    drain_results();
    configure_panel(10'd1, 10'd1, 10'd0, 10'd0);
    send_glyph_row(10'd0, 10'd0, "A", 3'd0, 8'hFF, 16'hFFFF, 16'h0000, 1'b0);
    drain_results();
    configure_panel(10'd0, 10'd0, 10'd0, 10'd0);
    send_glyph_row(10'd0, 10'd0, "A", 3'd0, 8'hFF, 16'hFFFF, 16'h0000, 1'b0);
    drain_results();
    // Smallest panel that still fits a 1x cell but not a 2x one.
    configure_panel(10'd6, 10'd8, 10'd0, 10'd0);
    send_glyph_row(10'd0, 10'd0, "B", 3'd0, 8'hF0, 16'hCAFE, 16'h0BAD, 1'b0);
    send_glyph_row(10'd0, 10'd0, "B", 3'd0, 8'hF0, 16'hCAFE, 16'h0BAD, 1'b1);
  endtask

  // Whole characters with random content, plus stray rows and cells anywhere.
  task automatic test_random_rendering();
    int          start;
    int          pick;
    int          xs;
    int          ys;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [7:0]  ch;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        dbl;
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      configure_panel(10'($urandom_range(12, 1023)), 10'($urandom_range(16, 1023)),
                      10'($urandom_range(1023)), 10'($urandom_range(1023)));
      steady = (phase == 2);
      start = rows_rendered;
      while (rows_rendered - start < 110) begin
        dbl = 1'($urandom_range(1));
        xs = dbl ? int'(XSPAN_2X) : int'(XSPAN_1X);
        ys = dbl ? int'(YSPAN_2X) : int'(YSPAN_1X);
        pick = $urandom_range(99);
        if (pick < 30) ch = CHAR_ZERO + 8'($urandom_range(9));
        else if (pick < 40) ch = 8'($urandom_range(255));
        else ch = 8'($urandom_range(32, 126));
        fg = 16'($urandom_range(65535));
        bg = 16'($urandom_range(65535));
        if ($urandom_range(99) < 85) begin
          x = 10'($urandom_range(int'(panel_width) - 1 - xs));
          y = 10'($urandom_range(int'(panel_height) - 1 - ys));
        end else begin
          x = 10'($urandom_range(1023));
          y = 10'($urandom_range(1023));
        end
        if ($urandom_range(99) < 80) begin
          for (int r = 0; r < 8; r++)
            send_glyph_row(x, y, ch, 3'(r), 8'($urandom_range(255)), fg, bg, dbl);
        end else begin
          send_glyph_row(x, y, ch, 3'($urandom_range(7)), 8'($urandom_range(255)),
                         fg, bg, dbl);
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    pop <= !rst && (steady || $urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (render_queue.size() == 0) begin
        $error("unexpected result: result_kind %0d pixel_colour %h", result_kind,
               pixel_colour);
        mismatches++;
      end else begin
        want = render_queue.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind expected %0d actual %0d", want.kind, result_kind);
          mismatches++;
        end
        if (window_start !== want.wstart) begin
          $error("window_start expected %0d actual %0d", want.wstart, window_start);
          mismatches++;
        end
        if (window_end !== want.wend) begin
          $error("window_end expected %0d actual %0d", want.wend, window_end);
          mismatches++;
        end
        if (pixel_colour !== want.colour) begin
          $error("pixel_colour expected %h actual %h", want.colour, pixel_colour);
          mismatches++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run expected %0d actual %0d", want.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_geometry();
    test_character_classes();
    test_register_extremes();
    test_random_rendering();
    drain_results();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
